// ----- src/hrlp_pkg.sv -----
// ----------------------------------------------------------------------------
// hrlp_pkg
// types, codes and byte helpers shared by the request line parser
// ----------------------------------------------------------------------------
package hrlp_pkg;

	localparam int MaxRes = 3;
	localparam int CntW   = 2;

	localparam logic [7:0] ChSpace   = 8'h20;
	localparam logic [7:0] ChPercent = 8'h25;
	localparam logic [7:0] ChPlus    = 8'h2b;
	localparam logic [7:0] ChMinus   = 8'h2d;
	localparam logic [7:0] ChQuest   = 8'h3f;
	localparam logic [7:0] ChAmp     = 8'h26;
	localparam logic [7:0] ChEqual   = 8'h3d;

	localparam logic [2:0] TagMethod  = 3'd0;
	localparam logic [2:0] TagPath    = 3'd1;
	localparam logic [2:0] TagKey     = 3'd2;
	localparam logic [2:0] TagValue   = 3'd3;
	localparam logic [2:0] TagVersion = 3'd4;

	localparam logic [2:0] StOk         = 3'd0;
	localparam logic [2:0] StNoSpace1   = 3'd1;
	localparam logic [2:0] StNoSpace2   = 3'd2;
	localparam logic [2:0] StNoMethod   = 3'd3;
	localparam logic [2:0] StNoPath     = 3'd4;
	localparam logic [2:0] StNoVersion  = 3'd5;

	localparam logic [1:0] EscNone = 2'd0;
	localparam logic [1:0] EscOpen = 2'd1;
	localparam logic [1:0] EscHeld = 2'd2;

	typedef enum logic [3:0] {
		PH_METHOD  = 4'b0001,
		PH_PATH    = 4'b0010,
		PH_QUERY   = 4'b0100,
		PH_VERSION = 4'b1000
	} phase_t;

	typedef struct packed {
		logic       has_byte;
		logic [7:0] out_byte;
		logic [2:0] field_tag;
		logic       param_end;
		logic       line_done;
		logic [2:0] status;
	} res_t;

	typedef struct packed {
		res_t [MaxRes-1:0] res;
		logic [CntW-1:0]   cnt;
	} batch_t;

	function automatic res_t mk_byte(input logic [7:0] b, input logic [2:0] tag);
		res_t r;
		r = '0;
		r.has_byte  = 1'b1;
		r.out_byte  = b;
		r.field_tag = tag;
		return r;
	endfunction

	function automatic res_t mk_pend();
		res_t r;
		r = '0;
		r.param_end = 1'b1;
		r.field_tag = TagKey;
		return r;
	endfunction

	function automatic res_t mk_done(input logic [2:0] st);
		res_t r;
		r = '0;
		r.line_done = 1'b1;
		r.field_tag = TagMethod;
		r.status    = st;
		return r;
	endfunction

	function automatic logic [7:0] path_char(input logic [7:0] c);
		return (c == ChPlus) ? ChSpace : c;
	endfunction

	// bit 4 set when the byte is a hex digit
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] h;
		h = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h = {1'b1, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			h = {1'b1, c[3:0] + 4'd9};
		end
		return h;
	endfunction

	function automatic logic [7:0] decode_pair(input logic [7:0] a, input logic [7:0] b);
		logic [4:0] ha;
		logic [4:0] hb;
		logic [7:0] v;
		ha = hex_val(a);
		hb = hex_val(b);
		v  = '0;
		if (a == ChSpace || (a >= 8'd9 && a <= 8'd13) || a == ChPlus) begin
			v = hb[4] ? {4'd0, hb[3:0]} : 8'd0;
		end else if (a == ChMinus) begin
			v = hb[4] ? (8'd0 - {4'd0, hb[3:0]}) : 8'd0;
		end else if (ha[4]) begin
			v = hb[4] ? {ha[3:0], hb[3:0]} : {4'd0, ha[3:0]};
		end
		return v;
	endfunction

endpackage

// ----- src/hrlp_line_if.sv -----
// ----------------------------------------------------------------------------
// hrlp_line_if
// byte channel into the parser
// ----------------------------------------------------------------------------
interface hrlp_line_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

// ----- src/hrlp_field_if.sv -----
// ----------------------------------------------------------------------------
// hrlp_field_if
// parsed result channel out of the parser
// ----------------------------------------------------------------------------
interface hrlp_field_if;
	logic       valid;
	logic       ready;
	logic       has_byte;
	logic [7:0] out_byte;
	logic [2:0] field_tag;
	logic       param_end;
	logic       line_done;
	logic [2:0] status;
	logic       last_result;

	modport source (output valid, output has_byte, output out_byte, output field_tag,
		output param_end, output line_done, output status, output last_result,
		input ready);
	modport sink (input valid, input has_byte, input out_byte, input field_tag,
		input param_end, input line_done, input status, input last_result,
		output ready);
endinterface

// ----- src/hrlp_parse.sv -----
// ----------------------------------------------------------------------------
// hrlp_parse
// parser state and the results of one byte
// ----------------------------------------------------------------------------
module hrlp_parse
	import hrlp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output batch_t     batch
);

	phase_t     phase_q,   phase_c;
	logic       mseen_q,   mseen_c;
	logic       pseen_q,   pseen_c;
	logic       vseen_q,   vseen_c;
	logic [1:0] pcnt_q,    pcnt_c;
	logic [7:0] held_q,    held_c;
	logic       inval_q,   inval_c;
	logic       popen_q,   popen_c;
	logic [2:0] st_c;
	logic [CntW-1:0] n_c;

	always_comb begin
		phase_c = phase_q;
		mseen_c = mseen_q;
		pseen_c = pseen_q;
		vseen_c = vseen_q;
		pcnt_c  = pcnt_q;
		held_c  = held_q;
		inval_c = inval_q;
		popen_c = popen_q;
		st_c    = StOk;
		n_c     = '0;
		batch   = '0;

		unique case (phase_q)
			PH_METHOD: begin
				if (in_byte == ChSpace) begin
					phase_c = PH_PATH;
				end else begin
					mseen_c = 1'b1;
					batch.res[n_c] = mk_byte(in_byte, TagMethod);
					n_c = n_c + 1'b1;
				end
			end
			PH_PATH: begin
				if (in_byte == ChSpace || in_byte == ChQuest) begin
					if (pcnt_c != EscNone) begin
						batch.res[n_c] = mk_byte(ChPercent, TagPath);
						n_c = n_c + 1'b1;
					end
					if (pcnt_c == EscHeld) begin
						batch.res[n_c] = mk_byte(path_char(held_c), TagPath);
						n_c = n_c + 1'b1;
					end
					pcnt_c = EscNone;
					held_c = '0;
					if (in_byte == ChSpace) begin
						phase_c = PH_VERSION;
					end else begin
						phase_c = PH_QUERY;
						inval_c = 1'b0;
						popen_c = 1'b0;
					end
				end else begin
					pseen_c = 1'b1;
					priority if (pcnt_q == EscNone) begin
						if (in_byte == ChPercent) begin
							pcnt_c = EscOpen;
						end else begin
							batch.res[n_c] = mk_byte(path_char(in_byte), TagPath);
							n_c = n_c + 1'b1;
						end
					end else if (pcnt_q == EscOpen) begin
						held_c = in_byte;
						pcnt_c = EscHeld;
					end else begin
						batch.res[n_c] = mk_byte(decode_pair(held_q, in_byte), TagPath);
						n_c = n_c + 1'b1;
						pcnt_c = EscNone;
						held_c = '0;
					end
				end
			end
			PH_QUERY: begin
				priority if (in_byte == ChSpace) begin
					if (popen_q) begin
						batch.res[n_c] = mk_pend();
						n_c = n_c + 1'b1;
					end
					popen_c = 1'b0;
					inval_c = 1'b0;
					phase_c = PH_VERSION;
				end else if (in_byte == ChAmp) begin
					batch.res[n_c] = mk_pend();
					n_c = n_c + 1'b1;
					popen_c = 1'b0;
					inval_c = 1'b0;
				end else if (in_byte == ChEqual && !inval_q) begin
					inval_c = 1'b1;
					popen_c = 1'b1;
				end else begin
					popen_c = 1'b1;
					batch.res[n_c] = mk_byte(in_byte, inval_q ? TagValue : TagKey);
					n_c = n_c + 1'b1;
				end
			end
			PH_VERSION: begin
				vseen_c = 1'b1;
				batch.res[n_c] = mk_byte(in_byte, TagVersion);
				n_c = n_c + 1'b1;
			end
			default: begin
				phase_c = PH_METHOD;
			end
		endcase

		if (in_last) begin
			if (phase_c == PH_PATH) begin
				if (pcnt_c != EscNone) begin
					batch.res[n_c] = mk_byte(ChPercent, TagPath);
					n_c = n_c + 1'b1;
				end
				if (pcnt_c == EscHeld) begin
					batch.res[n_c] = mk_byte(path_char(held_c), TagPath);
					n_c = n_c + 1'b1;
				end
			end
			if (phase_c == PH_QUERY && popen_c) begin
				batch.res[n_c] = mk_pend();
				n_c = n_c + 1'b1;
			end
			priority if (phase_c == PH_METHOD) st_c = StNoSpace1;
			else if (phase_c != PH_VERSION)    st_c = StNoSpace2;
			else if (!mseen_c)                 st_c = StNoMethod;
			else if (!pseen_c)                 st_c = StNoPath;
			else if (!vseen_c)                 st_c = StNoVersion;
			else                               st_c = StOk;
			batch.res[n_c] = mk_done(st_c);
			n_c = n_c + 1'b1;
			phase_c = PH_METHOD;
			mseen_c = 1'b0;
			pseen_c = 1'b0;
			vseen_c = 1'b0;
			pcnt_c  = EscNone;
			held_c  = '0;
			inval_c = 1'b0;
			popen_c = 1'b0;
		end
		batch.cnt = n_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_METHOD;
			mseen_q <= 1'b0;
			pseen_q <= 1'b0;
			vseen_q <= 1'b0;
			pcnt_q  <= EscNone;
			held_q  <= '0;
			inval_q <= 1'b0;
			popen_q <= 1'b0;
		end else if (take) begin
			phase_q <= phase_c;
			mseen_q <= mseen_c;
			pseen_q <= pseen_c;
			vseen_q <= vseen_c;
			pcnt_q  <= pcnt_c;
			held_q  <= held_c;
			inval_q <= inval_c;
			popen_q <= popen_c;
		end
	end

`ifndef SYNTHESIS
	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		take && in_last |=> phase_q == PH_METHOD && pcnt_q == EscNone && !popen_q)
		else $error("state not cleared after end of line");
	a_last_has_done: assert property (@(posedge clk) disable iff (!arst_n)
		in_last |-> batch.cnt != '0)
		else $error("end of line gives no result");
	a_escape_path_only: assert property (@(posedge clk) disable iff (!arst_n)
		pcnt_q != EscNone |-> phase_q == PH_PATH)
		else $error("escape open outside the path");
`endif

endmodule

// ----- src/hrlp_rbuf.sv -----
// ----------------------------------------------------------------------------
// hrlp_rbuf
// result register holding the results of one byte, handed out one per cycle while the result side is ready
// ----------------------------------------------------------------------------
module hrlp_rbuf
	import hrlp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  batch_t       batch,
	output logic         room,
	hrlp_field_if.source field_ch
);

	res_t            res_q [MaxRes];
	logic [CntW-1:0] rem_q;
	logic [CntW-1:0] rd_q;
	res_t            cur;

	assign cur  = res_q[rd_q];
	assign room = (rem_q == '0) || (rem_q == CntW'(1) && field_ch.ready);

	assign field_ch.valid       = rem_q != '0;
	assign field_ch.has_byte    = cur.has_byte;
	assign field_ch.out_byte    = cur.out_byte;
	assign field_ch.field_tag   = cur.field_tag;
	assign field_ch.param_end   = cur.param_end;
	assign field_ch.line_done   = cur.line_done;
	assign field_ch.status      = cur.status;
	assign field_ch.last_result = rem_q == CntW'(1);

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < MaxRes; i++) begin
				res_q[i] <= batch.res[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			rd_q  <= '0;
		end else if (load) begin
			rem_q <= batch.cnt;
			rd_q  <= '0;
		end else if (field_ch.valid && field_ch.ready) begin
			rem_q <= rem_q - 1'b1;
			rd_q  <= rd_q + 1'b1;
		end
	end

`ifndef SYNTHESIS
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> rem_q == '0 || (rem_q == CntW'(1) && field_ch.ready))
		else $error("results overwritten before delivery");
	a_window: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, rd_q} + {1'b0, rem_q}) <= (CntW + 1)'(MaxRes))
		else $error("read window beyond stored results");
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		field_ch.valid && field_ch.line_done |-> field_ch.last_result)
		else $error("end of line result is not the last of its byte");
`endif

endmodule

// ----- src/http_request_line_parser_top.sv -----
// ----------------------------------------------------------------------------
// http_request_line_parser_top
// streaming http request line parser with path percent decoding
// ----------------------------------------------------------------------------
// Each byte is taken into an input register, from which the parser works it
// out into zero to three results; a result register hands these out one per
// cycle while the result side is ready, with last_result on the final one. A
// byte that yields several results (short escape flushes, end of line) holds
// the input until its last result is taken, set by the single result port.
// Plain text streams at a byte per clock while the result side is ready.
// ----------------------------------------------------------------------------
module http_request_line_parser_top
	import hrlp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	hrlp_line_if.sink    line_ch,
	hrlp_field_if.source field_ch
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       room;
	logic       take;
	batch_t     batch;

	assign take          = valid_s1 && room;
	assign line_ch.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (line_ch.valid && line_ch.ready) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (line_ch.valid && line_ch.ready) begin
			byte_s1 <= line_ch.in_byte;
			last_s1 <= line_ch.in_last;
		end
	end

	hrlp_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.in_byte (byte_s1),
		.in_last (last_s1),
		.batch   (batch)
	);

	hrlp_rbuf u_rbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (take),
		.batch    (batch),
		.room     (room),
		.field_ch (field_ch)
	);

endmodule

// ----- bench/hrlp_field_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrlp_field_checker
// Watches both channels of the request line parser. Every accepted input byte
// is run through a local parse of the start line: method, path with percent
// decoding, query parameters and version. The results it should cause are
// queued, and each accepted result is compared with the oldest one queued.
// ----------------------------------------------------------------------------
module hrlp_field_checker
	import hrlp_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	hrlp_line_if   line_mon,
	hrlp_field_if  field_mon,
	output int     fails,
	output int     owed
);

	typedef struct packed {
		logic       has_byte;
		logic [7:0] out_byte;
		logic [2:0] field_tag;
		logic       param_end;
		logic       line_done;
		logic [2:0] status;
		logic       last_result;
	} field_item_t;

	field_item_t expected_fields[$];
	field_item_t got;
	field_item_t want;
	int          miss_count = 0;

	phase_t      cur_phase = PH_METHOD;
	bit          saw_method = 1'b0;
	bit          saw_path = 1'b0;
	bit          saw_version = 1'b0;
	bit          in_value = 1'b0;
	bit          param_open = 1'b0;
	logic [1:0]  esc_state = EscNone;
	logic [7:0]  esc_first = 8'h00;

	function automatic string show(input field_item_t f);
		return $sformatf("has=%0d byte=%02h tag=%0d pend=%0d done=%0d st=%0d last=%0d",
			f.has_byte, f.out_byte, f.field_tag, f.param_end, f.line_done, f.status,
			f.last_result);
	endfunction

	function automatic int nibble(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) return int'(c) - 48;
		if (c >= 8'h61 && c <= 8'h66) return int'(c) - 87;
		if (c >= 8'h41 && c <= 8'h46) return int'(c) - 55;
		return -1;
	endfunction

	// two escape bytes read as a base 16 number, low byte kept
	function automatic logic [7:0] escape_value(input logic [7:0] a, input logic [7:0] b);
		int hi;
		int lo;
		logic [7:0] v;
		hi = nibble(a);
		lo = nibble(b);
		v = 8'h00;
		if (a == ChSpace || (a >= 8'd9 && a <= 8'd13) || a == ChPlus) begin
			if (lo >= 0) v = lo[7:0];
		end else if (a == ChMinus) begin
			if (lo >= 0) v = 8'(256 - lo);
		end else if (hi >= 0) begin
			v = (lo >= 0) ? 8'(hi * 16 + lo) : hi[7:0];
		end
		return v;
	endfunction

	function automatic logic [7:0] path_byte(input logic [7:0] c);
		return (c == ChPlus) ? ChSpace : c;
	endfunction

	task automatic note(input logic has, input logic [7:0] b, input logic [2:0] tag,
		input logic pend, input logic done, input logic [2:0] st);
		field_item_t f;
		f = {has, b, tag, pend, done, st, 1'b0};
		expected_fields.push_back(f);
	endtask

	task automatic clear_line();
		cur_phase = PH_METHOD;
		saw_method = 1'b0;
		saw_path = 1'b0;
		saw_version = 1'b0;
		in_value = 1'b0;
		param_open = 1'b0;
		esc_state = EscNone;
		esc_first = 8'h00;
	endtask

	// an escape cut short comes out raw
	task automatic drain_escape();
		if (esc_state != EscNone) note(1'b1, ChPercent, TagPath, 1'b0, 1'b0, StOk);
		if (esc_state == EscHeld) note(1'b1, path_byte(esc_first), TagPath, 1'b0, 1'b0, StOk);
		esc_state = EscNone;
		esc_first = 8'h00;
	endtask

	task automatic parse_byte(input logic [7:0] b, input logic last);
		int first;
		logic [2:0] st;
		first = expected_fields.size();
		case (cur_phase)
			PH_METHOD: begin
				if (b == ChSpace) begin
					cur_phase = PH_PATH;
				end else begin
					saw_method = 1'b1;
					note(1'b1, b, TagMethod, 1'b0, 1'b0, StOk);
				end
			end
			PH_PATH: begin
				if (b == ChSpace || b == ChQuest) begin
					drain_escape();
					if (b == ChSpace) begin
						cur_phase = PH_VERSION;
					end else begin
						cur_phase = PH_QUERY;
						in_value = 1'b0;
						param_open = 1'b0;
					end
				end else begin
					saw_path = 1'b1;
					if (esc_state == EscNone) begin
						if (b == ChPercent) esc_state = EscOpen;
						else note(1'b1, path_byte(b), TagPath, 1'b0, 1'b0, StOk);
					end else if (esc_state == EscOpen) begin
						esc_first = b;
						esc_state = EscHeld;
					end else begin
						note(1'b1, escape_value(esc_first, b), TagPath, 1'b0, 1'b0, StOk);
						esc_state = EscNone;
						esc_first = 8'h00;
					end
				end
			end
			PH_QUERY: begin
				if (b == ChSpace) begin
					if (param_open) note(1'b0, 8'h00, TagKey, 1'b1, 1'b0, StOk);
					param_open = 1'b0;
					in_value = 1'b0;
					cur_phase = PH_VERSION;
				end else if (b == ChAmp) begin
					note(1'b0, 8'h00, TagKey, 1'b1, 1'b0, StOk);
					param_open = 1'b0;
					in_value = 1'b0;
				end else if (b == ChEqual && !in_value) begin
					in_value = 1'b1;
					param_open = 1'b1;
				end else begin
					param_open = 1'b1;
					note(1'b1, b, in_value ? TagValue : TagKey, 1'b0, 1'b0, StOk);
				end
			end
			default: begin
				saw_version = 1'b1;
				note(1'b1, b, TagVersion, 1'b0, 1'b0, StOk);
			end
		endcase
		if (last) begin
			if (cur_phase == PH_PATH) drain_escape();
			if (cur_phase == PH_QUERY && param_open) note(1'b0, 8'h00, TagKey, 1'b1, 1'b0, StOk);
			if (cur_phase == PH_METHOD) st = StNoSpace1;
			else if (cur_phase != PH_VERSION) st = StNoSpace2;
			else if (!saw_method) st = StNoMethod;
			else if (!saw_path) st = StNoPath;
			else if (!saw_version) st = StNoVersion;
			else st = StOk;
			note(1'b0, 8'h00, TagMethod, 1'b0, 1'b1, st);
			clear_line();
		end
		if (expected_fields.size() > first)
			expected_fields[expected_fields.size() - 1].last_result = 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_line();
			expected_fields.delete();
			miss_count = 0;
		end else begin
			if (line_mon.valid && line_mon.ready) parse_byte(line_mon.in_byte, line_mon.in_last);
			if (field_mon.valid && field_mon.ready) begin
				got = {field_mon.has_byte, field_mon.out_byte, field_mon.field_tag,
					field_mon.param_end, field_mon.line_done, field_mon.status,
					field_mon.last_result};
				if (expected_fields.size() == 0) begin
					miss_count++;
					$display("%0t: unexpected result, expected none, actual %s", $time, show(got));
				end else begin
					want = expected_fields.pop_front();
					if (got !== want) begin
						miss_count++;
						$display("%0t: mismatch, expected %s, actual %s", $time, show(want),
							show(got));
					end
				end
			end
		end
		fails <= miss_count;
		owed <= expected_fields.size();
	end

endmodule

// ----- bench/http_request_line_parser_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_request_line_parser_top_test
// Feeds request lines into the parser: a few hand-made lines for the corner
// cases, then random lines, mostly well formed with random content, some
// truncated and some plain noise. Both sides idle at random; the result side
// stalls once for a long stretch and the byte side waits for the parser to
// drain early and at the end; the checker beside the block reports mismatches.
// ----------------------------------------------------------------------------
module http_request_line_parser_top_test
	import hrlp_pkg::*;
();

	localparam int QuietLimit = 2000;
	localparam int HoldCycles = 80;
	localparam int HoldAfter  = 120;
	localparam int TotalBytes = 320;
	localparam int TailCycles = 8;

	logic clk;
	logic arst_n;

	hrlp_line_if  line_ch ();
	hrlp_field_if field_ch ();

	int         fail_count;
	int         results_owed;
	int         bytes_sent = 0;
	int         quiet_cycles = 0;
	bit         steady = 1'b0;
	logic [7:0] line_buf[$];

	http_request_line_parser_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.line_ch  (line_ch),
		.field_ch (field_ch)
	);

	hrlp_field_checker field_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.line_mon  (line_ch),
		.field_mon (field_ch),
		.fails     (fail_count),
		.owed      (results_owed)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		while (!steady && $urandom_range(99) < 36) begin
			line_ch.valid <= 1'b0;
			@(posedge clk);
		end
		line_ch.valid <= 1'b1;
		line_ch.in_byte <= b;
		line_ch.in_last <= last;
		@(posedge clk);
		while (!line_ch.ready) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_line();
		foreach (line_buf[i]) send_byte(line_buf[i], i == line_buf.size() - 1);
	endtask

	task automatic drain();
		line_ch.valid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] token_char();
		case ($urandom_range(5))
			0, 1, 2: return 8'(8'h61 + $urandom_range(25));
			3: return 8'h2f;
			4: return 8'(8'h30 + $urandom_range(9));
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic logic [7:0] escape_char();
		case ($urandom_range(7))
			0: return 8'(8'h30 + $urandom_range(9));
			1: return 8'(8'h61 + $urandom_range(5));
			2: return 8'(8'h41 + $urandom_range(5));
			3: return 8'(8'd9 + $urandom_range(4));
			4: return ChPlus;
			5: return ChMinus;
			6: return 8'h78;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic build_line();
		int n;
		line_buf.delete();
		if ($urandom_range(99) < 15) begin
			// noise
			n = $urandom_range(1, 8);
			repeat (n) line_buf.push_back(8'($urandom_range(255)));
			return;
		end
		n = $urandom_range(4);
		repeat (n) line_buf.push_back(token_char());
		if ($urandom_range(19) != 0) line_buf.push_back(ChSpace);
		n = $urandom_range(5);
		repeat (n) begin
			case ($urandom_range(5))
				0: begin
					line_buf.push_back(ChPercent);
					line_buf.push_back(escape_char());
					line_buf.push_back(escape_char());
				end
				1: begin
					line_buf.push_back(ChPercent);
					line_buf.push_back(escape_char());
				end
				2: line_buf.push_back(ChPercent);
				3: line_buf.push_back(ChPlus);
				default: line_buf.push_back(token_char());
			endcase
		end
		if ($urandom_range(1) == 1) begin
			line_buf.push_back(ChQuest);
			n = $urandom_range(6);
			repeat (n) begin
				case ($urandom_range(3))
					0: line_buf.push_back(ChAmp);
					1: line_buf.push_back(ChEqual);
					default: line_buf.push_back(token_char());
				endcase
			end
		end
		if ($urandom_range(19) != 0) line_buf.push_back(ChSpace);
		n = $urandom_range(4);
		repeat (n) line_buf.push_back(($urandom_range(5) == 0) ? ChSpace : token_char());
		// truncated line
		if ($urandom_range(9) == 0 && line_buf.size() > 1)
			line_buf = line_buf[0:$urandom_range(line_buf.size() - 1)];
		if (line_buf.size() == 0) line_buf.push_back(token_char());
	endtask

	initial begin
		arst_n = 1'b0;
		line_ch.valid = 1'b0;
		line_ch.in_byte = 8'h00;
		line_ch.in_last = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// full line: escape led by a plus, empty and open parameters
		line_buf = '{8'hff, ChSpace, 8'h2f, ChPercent, ChPlus, 8'h61, ChQuest, 8'h78, ChEqual,
			8'h31, ChAmp, ChEqual, ChAmp, ChAmp, ChSpace, 8'h00};
		send_line();
		// short escape with a held byte at end of line
		line_buf = '{8'h41, ChSpace, ChPercent, 8'h32};
		send_line();
		line_buf = '{ChSpace};
		send_line();
		line_buf = '{8'h78};
		send_line();
		line_buf = '{ChSpace, ChSpace};
		send_line();
		drain();

		while (bytes_sent < TotalBytes) begin
			steady = (bytes_sent >= 200 && bytes_sent < 260);
			build_line();
			send_line();
		end
		steady = 1'b0;
		drain();
		repeat (TailCycles) @(posedge clk);
		if (fail_count == 0 && results_owed == 0) begin
			$display("[http_request_line_parser_top] OK");
		end else begin
			$display("[http_request_line_parser_top] ERROR");
		end
		$finish;
	end

	// result side: random stalls, one long hold-off
	initial begin
		bit held;
		held = 1'b0;
		field_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (!held && bytes_sent >= HoldAfter) begin
				held = 1'b1;
				field_ch.ready <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
			end
			field_ch.ready <= steady || ($urandom_range(99) >= 36);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (line_ch.valid && line_ch.ready) || (field_ch.valid && field_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QuietLimit) begin
			$display("[http_request_line_parser_top] ERROR");
			$finish;
		end
	end

endmodule
